### rtl/liu_pkg.sv
// Shared types and constants of the linear interpolation upsampler.
`default_nettype none

package liu_pkg;

    // Width of the upsample factor register (fixed by the register map).
    localparam int FACTOR_REG_W = 5;

    // Reset value of the upsample factor register.
    localparam logic [FACTOR_REG_W-1:0] FACTOR_RESET = FACTOR_REG_W'(2);

    // Segment command kinds handed from the front end to the back end.
    typedef enum logic [1:0] {
        CMD_MID      = 2'd0,  // one segment, previous -> new sample
        CMD_LAST_ONE = 2'd1,  // one-sample block: closing segment only
        CMD_LAST_TWO = 2'd2   // previous -> new, then new -> first (closing)
    } liu_kind_t;

    // Flags that ride along with each result through the back-end pipe.
    typedef struct packed {
        logic run_end;
        logic block_end;
    } liu_flags_t;

endpackage : liu_pkg

`default_nettype wire

### rtl/linear_interp_upsampler.sv
// Top level of the linear interpolation upsampler.
//
//  Channel  | Direction | Handshake           | Payload
//  ---------+-----------+---------------------+-------------------------------------
//  cfg_*    | in        | cfg_valid/cfg_ready | cfg_upsample_factor (5b)
//  s_*      | in        | s_valid/s_ready     | s_in_sample (signed), s_block_last
//  m_*      | out       | m_valid/m_ready     | m_out_sample (signed), m_run_end,
//           |           |                     | m_block_end
//
// Results: the back-end sequencer emits one result per cycle unless m_ready
// holds the pipe, so a sample that continues a block yields f results, the
// last sample of a block 2f (f for a one-sample block), and a first sample
// none. f = 0 acts as 1, f above MAX_FACTOR as MAX_FACTOR. With the back end
// idle, a sample's first result passes the queue entry, sequencer load,
// weighted sum, reciprocal multiply and output register.
// Reset: synchronous, active low; clears block state, queue and pipe valids;
// the factor register returns to 2. No clearing pass is needed.
// Stalls: a full two-entry command queue stalls s_ready; m_ready low with
// m_valid high freezes the whole back-end pipe while the queue keeps filling.
`default_nettype none

module linear_interp_upsampler
    import liu_pkg::*;
#(
    parameter int MAX_FACTOR   = 16,
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    // configuration write
    input  wire logic                    cfg_valid,
    output logic                         cfg_ready,
    input  wire logic [FACTOR_REG_W-1:0] cfg_upsample_factor,
    // sample input
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [SAMPLE_WIDTH-1:0] s_in_sample,
    input  wire logic                    s_block_last,
    // interpolated output
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic [SAMPLE_WIDTH-1:0]      m_out_sample,
    output logic                         m_run_end,
    output logic                         m_block_end
);

    localparam int FW    = $clog2(MAX_FACTOR + 1);
    localparam int CMD_W = 3 * SAMPLE_WIDTH + 2;

    // Factor register; cfg_ready is tied high, so every write is accepted.
    logic [FACTOR_REG_W-1:0] factor_reg;
    logic [FW-1:0]           eff_factor;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_reg <= FACTOR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            factor_reg <= cfg_upsample_factor;
        end
    end

    // Effective factor: zero means one, large values clamp to MAX_FACTOR.
    always_comb begin
        if (factor_reg == '0) begin
            eff_factor = FW'(1);
        end else if (int'(factor_reg) > MAX_FACTOR) begin
            eff_factor = FW'(MAX_FACTOR);
        end else begin
            eff_factor = FW'(factor_reg);
        end
    end

    // Front end -> queue -> back end
    logic             fe_cmd_valid;
    logic             fe_cmd_ready;
    logic [CMD_W-1:0] fe_cmd_data;
    logic             be_cmd_valid;
    logic             be_cmd_ready;
    logic [CMD_W-1:0] be_cmd_data;

    liu_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_sample  (s_in_sample),
        .s_block_last (s_block_last),
        .cmd_valid    (fe_cmd_valid),
        .cmd_ready    (fe_cmd_ready),
        .cmd_data     (fe_cmd_data)
    );

    liu_cmd_fifo #(
        .WIDTH (CMD_W)
    ) u_cmd_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (fe_cmd_valid),
        .wr_ready (fe_cmd_ready),
        .wr_data  (fe_cmd_data),
        .rd_valid (be_cmd_valid),
        .rd_ready (be_cmd_ready),
        .rd_data  (be_cmd_data)
    );

    liu_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .MAX_FACTOR   (MAX_FACTOR)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .factor       (eff_factor),
        .cmd_valid    (be_cmd_valid),
        .cmd_ready    (be_cmd_ready),
        .cmd_data     (be_cmd_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_sample (m_out_sample),
        .m_run_end    (m_run_end),
        .m_block_end  (m_block_end)
    );

endmodule : linear_interp_upsampler

`default_nettype wire

### rtl/liu_cmd_fifo.sv
// Two-entry command queue between the front end and the back end.
`default_nettype none

module liu_cmd_fifo #(
    parameter int WIDTH = 74
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             wr_valid,
    output logic                  wr_ready,
    input  wire logic [WIDTH-1:0] wr_data,
    output logic                  rd_valid,
    input  wire logic             rd_ready,
    output logic [WIDTH-1:0]      rd_data
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;
    logic             do_wr;
    logic             do_rd;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_comb begin
        count_next = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + 2'd1;
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (do_wr) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (do_rd) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

endmodule : liu_cmd_fifo

`default_nettype wire

### rtl/liu_front.sv
// Front end: accepts samples, tracks block state, issues segment commands.
`default_nettype none

module liu_front
    import liu_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [SAMPLE_WIDTH-1:0] s_in_sample,
    input  wire logic                    s_block_last,
    output logic                         cmd_valid,
    input  wire logic                    cmd_ready,
    output logic [3*SAMPLE_WIDTH+1:0]    cmd_data
);

    logic                    have_prev_reg;
    logic                    have_prev_next;
    logic [SAMPLE_WIDTH-1:0] prev_reg;
    logic [SAMPLE_WIDTH-1:0] first_reg;
    logic                    accept;
    liu_kind_t               kind;
    logic [SAMPLE_WIDTH-1:0] seg_a;
    logic [SAMPLE_WIDTH-1:0] seg_c;

    // Held off whenever the queue is full, even for a first sample that issues no command.
    assign s_ready = cmd_ready;
    assign accept  = s_valid && s_ready;

    always_comb begin
        kind  = CMD_MID;
        seg_a = prev_reg;
        seg_c = first_reg;
        if (!have_prev_reg) begin
            // one-sample block: segment from the sample back to itself
            kind  = CMD_LAST_ONE;
            seg_a = s_in_sample;
            seg_c = s_in_sample;
        end else if (s_block_last) begin
            kind = CMD_LAST_TWO;
        end
    end

    assign cmd_valid = accept && (have_prev_reg || s_block_last);
    assign cmd_data  = {kind, seg_a, s_in_sample, seg_c};

    always_comb begin
        have_prev_next = have_prev_reg;
        if (accept) begin
            have_prev_next = !s_block_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            prev_reg <= s_in_sample;
            if (!have_prev_reg) begin
                first_reg <= s_in_sample;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_prev_reg <= 1'b0;
        end else begin
            have_prev_reg <= have_prev_next;
        end
    end

endmodule : liu_front

`default_nettype wire

### rtl/liu_back.sv
// Back end: walks segment commands and computes interpolated samples.
`default_nettype none

module liu_back
    import liu_pkg::*;
#(
    parameter int SAMPLE_WIDTH = 24,
    parameter int MAX_FACTOR   = 16
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [$clog2(MAX_FACTOR+1)-1:0] factor,
    input  wire logic                            cmd_valid,
    output logic                                 cmd_ready,
    input  wire logic [3*SAMPLE_WIDTH+1:0]       cmd_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [SAMPLE_WIDTH-1:0]              m_out_sample,
    output logic                                 m_run_end,
    output logic                                 m_block_end
);

    localparam int W     = SAMPLE_WIDTH;
    localparam int FW    = $clog2(MAX_FACTOR + 1);
    localparam int NUM_W = W + FW;          // signed weighted sum
    localparam int MAG_W = NUM_W;           // its magnitude
    localparam int K     = MAG_W;           // reciprocal scale 2^K
    localparam int M_W   = K + 1;
    localparam int P_W   = MAG_W + M_W;
    localparam logic [K:0] ONE_K = (K+1)'(1) << K;

    // floor(2^K / f) for each factor
    logic [M_W-1:0] recip_tab [MAX_FACTOR+1];
    for (genvar i = 0; i <= MAX_FACTOR; i++) begin : g_recip
        localparam int DIV = (i == 0) ? 1 : i;
        localparam logic [M_W-1:0] RECIP = M_W'(ONE_K / DIV);
        assign recip_tab[i] = RECIP;
    end

    // ---------------- sequencer ----------------
    logic            busy_reg;
    logic [W-1:0]    a_reg;
    logic [W-1:0]    b_reg;
    logic [W-1:0]    c_reg;
    logic [FW-1:0]   r_reg;
    logic            more_reg;
    logic            closing_reg;
    logic            adv;
    logic            step;
    logic            last_r;
    logic            finish;
    liu_kind_t       cmd_kind;

    assign adv       = !m_valid || m_ready;
    assign step      = busy_reg && adv;
    assign last_r    = (r_reg == FW'(factor - FW'(1)));
    assign finish    = step && last_r && !more_reg;
    assign cmd_ready = !busy_reg || finish;
    assign cmd_kind  = liu_kind_t'(cmd_data[3*W+1:3*W]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (cmd_valid && cmd_ready) begin
            busy_reg    <= 1'b1;
            a_reg       <= cmd_data[3*W-1:2*W];
            b_reg       <= cmd_data[2*W-1:W];
            c_reg       <= cmd_data[W-1:0];
            r_reg       <= '0;
            more_reg    <= (cmd_kind == CMD_LAST_TWO);
            closing_reg <= (cmd_kind == CMD_LAST_ONE);
        end else if (step) begin
            if (!last_r) begin
                r_reg <= r_reg + FW'(1);
            end else if (more_reg) begin
                // second half of a block end: new sample back to first
                a_reg       <= b_reg;
                b_reg       <= c_reg;
                r_reg       <= '0;
                more_reg    <= 1'b0;
                closing_reg <= 1'b1;
            end else begin
                busy_reg <= 1'b0;
            end
        end
    end

    // ---------------- stage 1: weighted sum ----------------
    logic signed [NUM_W-1:0] a_ext;
    logic signed [NUM_W-1:0] b_ext;
    logic signed [NUM_W-1:0] wa;
    logic signed [NUM_W-1:0] wb;
    logic signed [NUM_W-1:0] num_next;
    logic signed [NUM_W-1:0] num1_reg;
    logic                    v1_reg;
    liu_flags_t              fl_next;
    liu_flags_t              fl1_reg;

    assign a_ext    = {{FW{a_reg[W-1]}}, a_reg};
    assign b_ext    = {{FW{b_reg[W-1]}}, b_reg};
    assign wa       = {{W{1'b0}}, FW'(factor - r_reg)};
    assign wb       = {{W{1'b0}}, r_reg};
    assign num_next = a_ext * wa + b_ext * wb;

    assign fl_next.run_end   = last_r && !more_reg;
    assign fl_next.block_end = last_r && closing_reg;

    // ---------------- stage 2: reciprocal multiply ----------------
    logic [MAG_W-1:0] mag_next;
    logic [P_W-1:0]   prod_next;
    logic [MAG_W-1:0] mag2_reg;
    logic [P_W-1:0]   prod2_reg;
    logic             neg2_reg;
    logic             v2_reg;
    liu_flags_t       fl2_reg;

    assign mag_next  = num1_reg[NUM_W-1] ? MAG_W'(-num1_reg) : MAG_W'(num1_reg);
    assign prod_next = P_W'(mag_next) * P_W'(recip_tab[factor]);

    // ---------------- stage 3: correction and sign ----------------
    logic [MAG_W-1:0]    q0;
    logic [MAG_W+FW-1:0] qf_full;
    logic [MAG_W-1:0]    rem;
    logic [MAG_W-1:0]    q;
    logic [MAG_W-1:0]    res_next;

    assign q0       = prod2_reg[K +: MAG_W];
    assign qf_full  = (MAG_W+FW)'(q0) * (MAG_W+FW)'(factor);
    assign rem      = mag2_reg - qf_full[MAG_W-1:0];
    assign q        = q0 + MAG_W'(rem >= MAG_W'(factor));
    assign res_next = neg2_reg ? -q : q;

    logic            out_valid_reg;
    logic [W-1:0]    out_sample_reg;
    liu_flags_t      out_fl_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            num1_reg       <= num_next;
            fl1_reg        <= fl_next;
            mag2_reg       <= mag_next;
            prod2_reg      <= prod_next;
            neg2_reg       <= num1_reg[NUM_W-1];
            fl2_reg        <= fl1_reg;
            out_sample_reg <= res_next[W-1:0];
            out_fl_reg     <= fl2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg        <= busy_reg;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_out_sample = out_sample_reg;
    assign m_run_end    = out_fl_reg.run_end;
    assign m_block_end  = out_fl_reg.block_end;

endmodule : liu_back

`default_nettype wire
